FILE: rtl/p2c_pkg.sv
package p2c_pkg;

  // default configuration
  localparam int unsigned DataWidthDef      = 16;
  localparam int unsigned RotationStagesDef = 16;

  // field widths
  localparam int unsigned RadiusWidth = 16;
  localparam int unsigned AngleWidth  = 16;
  localparam int unsigned CoordWidth  = 17;
  localparam int unsigned InBytesW    = 32;
  localparam int unsigned OutBytesW   = 40;

  // cordic gain 0.60725293500888 in unsigned q0.32, truncated
  localparam logic [31:0] KGain      = 32'd2608131496;
  localparam int unsigned KGainFrac  = 32;

  // arctangent table depth and output clamp
  localparam int unsigned AtanEntries = 32;
  localparam int unsigned CoordLimit  = 65535;

  // angle folding: an eighth of a turn in 16-bit binary angle units
  localparam logic [AngleWidth-1:0] EighthTurn = 16'h2000;

  // quarter turn taken out of the angle before the micro-rotations
  typedef enum logic [1:0] {
    QuadZero,
    QuadQuarter,
    QuadHalf,
    QuadThreeQuarter
  } quadrant_e;

  // round(atan(2^-i) * 2^32 / (2*pi))
  function automatic logic [31:0] atan_turns(input logic [4:0] idx);
    logic [31:0] val;
    case (idx)
      5'd0:    val = 32'd536870912;
      5'd1:    val = 32'd316933406;
      5'd2:    val = 32'd167458907;
      5'd3:    val = 32'd85004756;
      5'd4:    val = 32'd42667331;
      5'd5:    val = 32'd21354465;
      5'd6:    val = 32'd10679838;
      5'd7:    val = 32'd5340245;
      5'd8:    val = 32'd2670163;
      5'd9:    val = 32'd1335087;
      5'd10:   val = 32'd667544;
      5'd11:   val = 32'd333772;
      5'd12:   val = 32'd166886;
      5'd13:   val = 32'd83443;
      5'd14:   val = 32'd41722;
      5'd15:   val = 32'd20861;
      5'd16:   val = 32'd10430;
      5'd17:   val = 32'd5215;
      5'd18:   val = 32'd2608;
      5'd19:   val = 32'd1304;
      5'd20:   val = 32'd652;
      5'd21:   val = 32'd326;
      5'd22:   val = 32'd163;
      5'd23:   val = 32'd81;
      5'd24:   val = 32'd41;
      5'd25:   val = 32'd20;
      5'd26:   val = 32'd10;
      5'd27:   val = 32'd5;
      5'd28:   val = 32'd3;
      5'd29:   val = 32'd1;
      5'd30:   val = 32'd1;
      default: val = 32'd0;
    endcase
    return val;
  endfunction

endpackage

FILE: rtl/p2c_prep.sv
module p2c_prep #(
  parameter int unsigned DATA_WIDTH = p2c_pkg::DataWidthDef,
  parameter int unsigned XW         = p2c_pkg::RadiusWidth + DATA_WIDTH + 2,
  parameter int unsigned ZW         = 34
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 ce_i,
  input  logic                                 valid_i,
  input  logic [p2c_pkg::RadiusWidth-1:0]      radius_i,
  input  logic [p2c_pkg::AngleWidth-1:0]       angle_i,
  output logic                                 valid_o,
  output logic [1:0]                           quadrant_o,
  output logic signed [XW-1:0]                 x_o,
  output logic signed [ZW-1:0]                 z_o
);

  localparam int unsigned ProdW  = p2c_pkg::RadiusWidth + 32;
  localparam int unsigned StartW = p2c_pkg::RadiusWidth + DATA_WIDTH;
  localparam int unsigned Shift  = p2c_pkg::KGainFrac - DATA_WIDTH;

  logic [ProdW-1:0]                 prod;
  logic [ProdW-1:0]                 prod_sh;
  logic [p2c_pkg::AngleWidth-1:0]   folded;
  logic signed [15:0]               residual;

  logic                             valid_q;
  logic [1:0]                       quadrant_d, quadrant_q;
  logic signed [XW-1:0]             x_d, x_q;
  logic signed [ZW-1:0]             z_d, z_q;

  // gain-compensated start value and angle fold to a quadrant
  always_comb begin
    prod       = {32'b0, radius_i} * {{p2c_pkg::RadiusWidth{1'b0}}, p2c_pkg::KGain};
    prod_sh    = prod >> Shift;
    x_d        = signed'({2'b0, prod_sh[StartW-1:0]});
    folded     = angle_i + p2c_pkg::EighthTurn;
    quadrant_d = folded[15:14];
    residual   = signed'({2'b0, folded[13:0]}) - signed'({1'b0, p2c_pkg::EighthTurn[14:0]});
    z_d        = ZW'(residual) <<< 16;
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ce_i) begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      quadrant_q <= quadrant_d;
      x_q        <= x_d;
      z_q        <= z_d;
    end
  end

  assign valid_o    = valid_q;
  assign quadrant_o = quadrant_q;
  assign x_o        = x_q;
  assign z_o        = z_q;

endmodule

FILE: rtl/p2c_rotator.sv
module p2c_rotator #(
  parameter int unsigned STAGE = 0,
  parameter int unsigned XW    = p2c_pkg::RadiusWidth + p2c_pkg::DataWidthDef + 2,
  parameter int unsigned ZW    = 34
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  ce_i,
  input  logic                  valid_i,
  input  logic [1:0]            quadrant_i,
  input  logic signed [XW-1:0]  x_i,
  input  logic signed [XW-1:0]  y_i,
  input  logic signed [ZW-1:0]  z_i,
  output logic                  valid_o,
  output logic [1:0]            quadrant_o,
  output logic signed [XW-1:0]  x_o,
  output logic signed [XW-1:0]  y_o,
  output logic signed [ZW-1:0]  z_o
);

  localparam logic [31:0] AtanU = p2c_pkg::atan_turns(5'(STAGE));
  localparam logic signed [ZW-1:0] Atan = ZW'(signed'({1'b0, AtanU}));

  logic signed [XW-1:0] dx, dy;
  logic signed [XW-1:0] x_d, y_d, x_q, y_q;
  logic signed [ZW-1:0] z_d, z_q;
  logic [1:0]           quadrant_q;
  logic                 valid_q;

  // one micro-rotation toward zero residual angle
  always_comb begin
    dx = y_i >>> STAGE;
    dy = x_i >>> STAGE;
    if (!z_i[ZW-1]) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - Atan;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + Atan;
    end
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ce_i) begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      quadrant_q <= quadrant_i;
      x_q        <= x_d;
      y_q        <= y_d;
      z_q        <= z_d;
    end
  end

  assign valid_o    = valid_q;
  assign quadrant_o = quadrant_q;
  assign x_o        = x_q;
  assign y_o        = y_q;
  assign z_o        = z_q;

endmodule

FILE: rtl/p2c_post.sv
module p2c_post #(
  parameter int unsigned DATA_WIDTH = p2c_pkg::DataWidthDef,
  parameter int unsigned XW         = p2c_pkg::RadiusWidth + DATA_WIDTH + 2
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  ce_i,
  input  logic                                  valid_i,
  input  logic [1:0]                            quadrant_i,
  input  logic signed [XW-1:0]                  x_i,
  input  logic signed [XW-1:0]                  y_i,
  output logic                                  valid_o,
  output logic signed [p2c_pkg::CoordWidth-1:0] x_coord_o,
  output logic signed [p2c_pkg::CoordWidth-1:0] y_coord_o
);

  localparam logic signed [XW-1:0] Half   = XW'(1) <<< (DATA_WIDTH - 1);
  localparam logic signed [XW-1:0] PosLim = XW'(p2c_pkg::CoordLimit);
  localparam logic signed [XW-1:0] NegLim = -PosLim;

  logic signed [XW-1:0] fx, fy, rx, ry;
  logic signed [p2c_pkg::CoordWidth-1:0] x_d, y_d, x_q, y_q;
  logic valid_q;

  function automatic logic signed [XW-1:0] clamp(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] r;
    r = v;
    if (v > PosLim) r = PosLim;
    if (v < NegLim) r = NegLim;
    return r;
  endfunction

  // exact quadrant rotation, then round half up and saturate
  always_comb begin
    case (quadrant_i)
      p2c_pkg::QuadZero:    begin fx = x_i;  fy = y_i;  end
      p2c_pkg::QuadQuarter: begin fx = -y_i; fy = x_i;  end
      p2c_pkg::QuadHalf:    begin fx = -x_i; fy = -y_i; end
      default:              begin fx = y_i;  fy = -x_i; end
    endcase
    rx  = clamp((fx + Half) >>> DATA_WIDTH);
    ry  = clamp((fy + Half) >>> DATA_WIDTH);
    x_d = rx[p2c_pkg::CoordWidth-1:0];
    y_d = ry[p2c_pkg::CoordWidth-1:0];
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ce_i) begin
      valid_q <= valid_i;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  assign valid_o   = valid_q;
  assign x_coord_o = x_q;
  assign y_coord_o = y_q;

endmodule

FILE: rtl/polar_to_cartesian.sv
// throughput: one request per cycle while the output is not stalled; the prep stage holds
// the 16x32 gain multiply, then one register stage per micro-rotation, then a rounding and output stage
// a stalled output freezes the whole pipeline, so input tready follows output space
// reset: rst_ni asynchronous active low clears every valid bit; no other state
module polar_to_cartesian #(
  parameter int unsigned DATA_WIDTH      = p2c_pkg::DataWidthDef,
  parameter int unsigned ROTATION_STAGES = p2c_pkg::RotationStagesDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // radius [15:0], angle [31:16]
  input  logic [p2c_pkg::InBytesW-1:0]    s_axis_tdata_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // x_coord [16:0], y_coord [33:17], zero [39:34]
  output logic [p2c_pkg::OutBytesW-1:0]   m_axis_tdata_o,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i
);

  localparam int unsigned NS = (ROTATION_STAGES < p2c_pkg::AtanEntries) ?
                               ROTATION_STAGES : p2c_pkg::AtanEntries;
  localparam int unsigned XW = p2c_pkg::RadiusWidth + DATA_WIDTH + 2;
  localparam int unsigned ZW = 34;

  logic                 ce;
  logic                 v_s  [0:NS];
  logic [1:0]           q_s  [0:NS];
  logic signed [XW-1:0] x_s  [0:NS];
  logic signed [XW-1:0] y_s  [0:NS];
  logic signed [ZW-1:0] z_s  [0:NS];
  logic signed [p2c_pkg::CoordWidth-1:0] x_coord, y_coord;

  // pipeline advances whenever the output register can take a request
  assign ce              = ~m_axis_tvalid_o | m_axis_tready_i;
  assign s_axis_tready_o = ce;

  // gain multiply and angle fold
  p2c_prep #(
    .DATA_WIDTH (DATA_WIDTH),
    .XW         (XW),
    .ZW         (ZW)
  ) u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ce_i       (ce),
    .valid_i    (s_axis_tvalid_i),
    .radius_i   (s_axis_tdata_i[15:0]),
    .angle_i    (s_axis_tdata_i[31:16]),
    .valid_o    (v_s[0]),
    .quadrant_o (q_s[0]),
    .x_o        (x_s[0]),
    .z_o        (z_s[0])
  );
  assign y_s[0] = '0;

  // micro-rotation stages
  for (genvar i = 0; i < NS; i++) begin : g_rot
    p2c_rotator #(
      .STAGE (i),
      .XW    (XW),
      .ZW    (ZW)
    ) u_rot (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ce_i       (ce),
      .valid_i    (v_s[i]),
      .quadrant_i (q_s[i]),
      .x_i        (x_s[i]),
      .y_i        (y_s[i]),
      .z_i        (z_s[i]),
      .valid_o    (v_s[i+1]),
      .quadrant_o (q_s[i+1]),
      .x_o        (x_s[i+1]),
      .y_o        (y_s[i+1]),
      .z_o        (z_s[i+1])
    );
  end

  // quadrant, rounding and output register
  p2c_post #(
    .DATA_WIDTH (DATA_WIDTH),
    .XW         (XW)
  ) u_post (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ce_i       (ce),
    .valid_i    (v_s[NS]),
    .quadrant_i (q_s[NS]),
    .x_i        (x_s[NS]),
    .y_i        (y_s[NS]),
    .valid_o    (m_axis_tvalid_o),
    .x_coord_o  (x_coord),
    .y_coord_o  (y_coord)
  );

  assign m_axis_tdata_o = {6'b0, y_coord, x_coord};

  // saturation keeps both coordinates inside the symmetric limit
  a_coord_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (x_coord >= -17'sd65535) && (x_coord <= 17'sd65535) &&
                        (y_coord >= -17'sd65535) && (y_coord <= 17'sd65535))
    else $error("coordinate outside saturation range");

  // a stalled pipeline holds its first stage
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ce |=> $stable(v_s[0]) && $stable(q_s[0]))
    else $error("prep stage changed during stall");

  // residual angle converges after the last micro-rotation
  a_residual: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_s[NS] |-> (z_s[NS] < (ZW'(1) <<< 30)) && (z_s[NS] > -(ZW'(1) <<< 30)))
    else $error("residual angle did not converge");

endmodule

FILE: bench/p2c_checker.sv
`timescale 1ns / 100ps

module p2c_checker
  import p2c_pkg::*;
#(
  parameter int unsigned DATA_WIDTH      = DataWidthDef,
  parameter int unsigned ROTATION_STAGES = RotationStagesDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // radius [15:0], angle [31:16]
  input  logic [InBytesW-1:0]  s_axis_tdata_i,
  input  logic                 s_axis_tvalid_i,
  input  logic                 s_axis_tready_i,
  // x_coord [16:0], y_coord [33:17], zero [39:34]
  input  logic [OutBytesW-1:0] m_axis_tdata_i,
  input  logic                 m_axis_tvalid_i,
  input  logic                 m_axis_tready_i,
  output int                   fail_count_o,
  output int                   outstanding_o
);

  localparam int unsigned PadWidth = OutBytesW - 2 * CoordWidth;

  // x sits in the low bits of the output request
  typedef struct packed {
    logic [CoordWidth-1:0] y;
    logic [CoordWidth-1:0] x;
  } point_t;

  // arctangent of 2^-i, in 2^32 units per turn
  longint atan_step [AtanEntries] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
    5, 3, 1, 1, 0
  };

  point_t cartesian_q [$];
  int     fails = 0;

  // drop the fraction with round-half-up, then clamp to the coordinate range
  function automatic logic [CoordWidth-1:0] round_clamp(input longint v);
    longint r;
    r = (v + (longint'(1) << (DATA_WIDTH - 1))) >>> DATA_WIDTH;
    if (r > longint'(CoordLimit)) r = longint'(CoordLimit);
    if (r < -longint'(CoordLimit)) r = -longint'(CoordLimit);
    return r[CoordWidth-1:0];
  endfunction

  // expected cartesian point for one polar request
  function automatic point_t polar_rotate(input logic [RadiusWidth-1:0] radius,
                                          input logic [AngleWidth-1:0]  angle);
    logic [AngleWidth-1:0] folded;
    quadrant_e             quadrant;
    longint unsigned       gain_prod;
    longint                x, y, z, dx, dy, fx, fy;
    point_t                pt;
    folded    = angle + EighthTurn;
    quadrant  = quadrant_e'(folded[AngleWidth-1 -: 2]);
    z         = (longint'(folded[AngleWidth-3:0]) - longint'(EighthTurn)) * 64'sd65536;
    gain_prod = 64'(radius) * 64'(KGain);
    x         = longint'(gain_prod >> (KGainFrac - DATA_WIDTH));
    y         = 0;
    for (int i = 0; i < ROTATION_STAGES && i < AtanEntries; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_step[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_step[i];
      end
    end
    case (quadrant)
      QuadZero: begin
        fx = x;
        fy = y;
      end
      QuadQuarter: begin
        fx = -y;
        fy = x;
      end
      QuadHalf: begin
        fx = -x;
        fy = -y;
      end
      default: begin
        fx = y;
        fy = -x;
      end
    endcase
    pt.x = round_clamp(fx);
    pt.y = round_clamp(fy);
    return pt;
  endfunction

  // compare each output request with the oldest prediction, then log new inputs
  always @(posedge clk_i) begin : watch
    point_t              want, got;
    logic [PadWidth-1:0] pad;
    if (rst_ni) begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = m_axis_tdata_i[2*CoordWidth-1:0];
        pad = m_axis_tdata_i[OutBytesW-1:2*CoordWidth];
        if (cartesian_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: unexpected result x=%0d y=%0d", $time,
                     $signed(got.x), $signed(got.y));
        end else begin
          want = cartesian_q.pop_front();
          if (got.x !== want.x || got.y !== want.y || pad !== '0) begin
            fails++;
            if (fails <= 10)
              $display("%0t: mismatch expected x=%0d y=%0d pad=0, got x=%0d y=%0d pad=%h",
                       $time, $signed(want.x), $signed(want.y),
                       $signed(got.x), $signed(got.y), pad);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        cartesian_q.push_back(polar_rotate(s_axis_tdata_i[RadiusWidth-1:0],
                                           s_axis_tdata_i[RadiusWidth +: AngleWidth]));
    end
    outstanding_o <= cartesian_q.size();
    fail_count_o  <= fails;
  end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import p2c_pkg::*;

  localparam int unsigned HoldCycles   = 80;
  localparam int unsigned RandomItems  = 1130;
  localparam int unsigned QuietItems   = 150;
  localparam int unsigned DrainCycles  = 3 * (RotationStagesDef + 2);

  logic                 clk_i    = 1'b0;
  logic                 rst_ni   = 1'b0;
  logic [InBytesW-1:0]  s_tdata  = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [OutBytesW-1:0] m_tdata;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic                 quiet    = 1'b0;
  logic                 hold_req = 1'b0;
  int                   fail_count;
  int                   outstanding;

  logic [RadiusWidth-1:0] dir_radius [3] = '{16'h0000, 16'h0001, 16'hFFFF};
  logic [AngleWidth-1:0]  dir_angle [8]  = '{16'h0000, 16'h1FFF, 16'h2000, 16'h4000,
                                             16'h6000, 16'h8000, 16'hC000, 16'hFFFF};

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  polar_to_cartesian u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready)
  );

  p2c_checker u_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .fail_count_o    (fail_count),
    .outstanding_o   (outstanding)
  );

  // offer one polar request, maybe after a short gap, and wait for acceptance
  task automatic send_polar(input logic [RadiusWidth-1:0] radius,
                            input logic [AngleWidth-1:0]  angle);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_tdata  <= {angle, radius};
    s_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
  endtask

  // output side: random stalls, one long hold-off on request
  initial begin : sink
    logic held;
    held = 1'b0;
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // reset, directed corners, random sweep, drain and verdict
  initial begin : stimulus
    logic [RadiusWidth-1:0] radius;
    logic [AngleWidth-1:0]  angle;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero, unit and full radius at octant edges and cardinal angles
    foreach (dir_radius[r])
      foreach (dir_angle[a])
        send_polar(dir_radius[r], dir_angle[a]);

    for (int n = 0; n < RandomItems; n++) begin
      if (n == 40) hold_req = 1'b1;
      if (n == RandomItems - QuietItems) quiet = 1'b1;
      case ($urandom_range(0, 9))
        0:       radius = 16'hFFFF - 16'($urandom_range(0, 3));
        1:       radius = 16'($urandom_range(0, 15));
        default: radius = 16'($urandom);
      endcase
      // octant boundaries are where the fold and saturation are touchiest
      if ($urandom_range(0, 7) == 0)
        angle = 16'($urandom_range(0, 7) << 13) + 16'($urandom_range(0, 2)) - 16'd1;
      else
        angle = 16'($urandom);
      send_polar(radius, angle);
    end

    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/p2c_pkg.sv
rtl/p2c_prep.sv
rtl/p2c_rotator.sv
rtl/p2c_post.sv
rtl/polar_to_cartesian.sv
bench/p2c_checker.sv
bench/tb_top.sv
